/* sv/cbe_pkg.sv */
// Shared types, constants and fixed-point helpers for the cubic Bezier easing unit.
// Holds the control-point table and coefficient derivation; no dependencies.
`timescale 1ns / 1ps
package cbe_pkg;

   localparam int FRAC_BITS         = 16;
   localparam int NEWTON_STEPS_DEF  = 10;
   localparam int NUM_CURVES_DEF    = 6;
   localparam int ROM_CURVES        = 6;

   localparam int SEL_W  = 3;
   localparam int X_W    = FRAC_BITS + 1;
   localparam int Y_W    = 19;
   localparam int VAL_W  = 24;
   localparam int QB     = 18;
   localparam int REM_W  = VAL_W + FRAC_BITS;
   localparam int CMP_W  = REM_W + 2;
   localparam int TS_W   = QB + 3;
   localparam int PROD_W = VAL_W + X_W + 1;

   typedef logic [SEL_W-1:0]         sel_type;
   typedef logic [X_W-1:0]           tq_type;
   typedef logic signed [VAL_W-1:0]  val_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [Y_W-1:0]    y_type;

   localparam sel_type  SEL_LINEAR = sel_type'(5);
   localparam tq_type   ONE_X      = tq_type'(longint'(1) << FRAC_BITS);
   localparam val_type  ONE_V      = val_type'(longint'(1) << FRAC_BITS);
   localparam prod_type HALF_P     = prod_type'(longint'(1) << (FRAC_BITS - 1));

   typedef struct packed {
      sel_type sel;
      tq_type  x;
      tq_type  t;
      logic    pass;
   } item_type;

   typedef struct packed {
      val_type c1;
      val_type c2;
      val_type c3;
      val_type d2;
      val_type d3;
   } poly_type;

   // round half up, floor shift
   function automatic val_type fx_mul(val_type a, tq_type b);
      prod_type p;
      p = prod_type'(a) * prod_type'($signed({1'b0, b}));
      p = p + HALF_P;
      return val_type'(p >>> FRAC_BITS);
   endfunction

   function automatic val_type hund_to_q(int h);
      return val_type'((longint'(h) * (longint'(1) << FRAC_BITS) + 50) / 100);
   endfunction

   function automatic poly_type curve_poly(sel_type sel, logic ycoord);
      int       h1x, h1y, h2x, h2y;
      val_type  p1, p2;
      poly_type r;
      case (sel)
         sel_type'(0): begin h1x = 25; h1y = 10; h2x = 25;  h2y = 100; end
         sel_type'(1): begin h1x = 42; h1y = 0;  h2x = 58;  h2y = 100; end
         sel_type'(2): begin h1x = 42; h1y = 0;  h2x = 100; h2y = 100; end
         sel_type'(3): begin h1x = 0;  h1y = 0;  h2x = 58;  h2y = 100; end
         sel_type'(4): begin h1x = 0;  h1y = 0;  h2x = 0;   h2y = 125; end
         default:      begin h1x = 0;  h1y = 0;  h2x = 100; h2y = 100; end
      endcase
      p1 = ycoord ? hund_to_q(h1y) : hund_to_q(h1x);
      p2 = ycoord ? hund_to_q(h2y) : hund_to_q(h2x);
      r.c1 = val_type'(3 * p1);
      r.c2 = val_type'(3 * p2 - 6 * p1);
      r.c3 = val_type'(ONE_V + 3 * p1 - 3 * p2);
      r.d2 = val_type'(2 * r.c2);
      r.d3 = val_type'(3 * r.c3);
      return r;
   endfunction

endpackage

/* sv/cubic_bezier_easing_eval_unit.sv */
// Cubic Bezier easing evaluator: top level. Uses cbe_pkg, cbe_newton_step,
// cbe_y_eval and cbe_skid_out.
`timescale 1ns / 1ps
// One word enters per cycle and one result leaves per cycle while the pipeline is not
// stalled. From accept to rsp_valid a word passes one input register loaded at the
// accepting edge, 23 stages per Newton step (three Horner multiply stages, a divider
// setup stage, an 18-stage one-bit-per-stage divider, a t update stage), four stages
// for By(t) and saturation, and the output register. The whole pipeline holds while
// the skid word is occupied, so up to two results may wait at the output without
// losing input throughput until both are full.
module cubic_bezier_easing_eval_unit #(
   parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF,
   parameter int NUM_CURVES   = cbe_pkg::NUM_CURVES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbe_pkg::sel_type req_curve_select,
   input  cbe_pkg::tq_type  req_progress_x,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbe_pkg::y_type   rsp_eased_y
);
   import cbe_pkg::*;

   logic     en;
   logic     v0_ff;
   item_type it0_ff, it_in;
   logic     sv [NEWTON_STEPS+1];
   item_type si [NEWTON_STEPS+1];
   logic     yv;
   y_type    yy;

   always_comb begin
      if (int'(req_curve_select) >= NUM_CURVES || int'(req_curve_select) >= ROM_CURVES)
         it_in.sel = SEL_LINEAR;
      else
         it_in.sel = req_curve_select;
      it_in.x    = (req_progress_x > ONE_X) ? ONE_X : req_progress_x;
      it_in.t    = it_in.x;
      it_in.pass = (it_in.x == '0) || (it_in.x == ONE_X);
   end

   always_ff @(posedge clock) begin
      if (reset)   v0_ff <= 1'b0;
      else if (en) v0_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) it0_ff <= it_in;
   end

   assign req_ready = en;
   assign sv[0] = v0_ff;
   assign si[0] = it0_ff;

   for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
      cbe_newton_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sv[s]),
         .in_item   (si[s]),
         .out_valid (sv[s+1]),
         .out_item  (si[s+1])
      );
   end

   cbe_y_eval u_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv[NEWTON_STEPS]),
      .in_item   (si[NEWTON_STEPS]),
      .out_valid (yv),
      .out_y     (yy)
   );

   cbe_skid_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (yv),
      .in_y        (yy),
      .en          (en),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_eased_y (rsp_eased_y)
   );

endmodule

/* sv/cbe_newton_step.sv */
// One Newton-Raphson step on Bx(t) = x: Horner stages, pipelined restoring divider,
// update and clamp of t. Depends on cbe_pkg.
`timescale 1ns / 1ps
module cbe_newton_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cbe_pkg::item_type in_item,
   output logic              out_valid,
   output cbe_pkg::item_type out_item
);
   import cbe_pkg::*;

   localparam int STAGES = QB + 5;
   localparam int PREP   = 3;

   logic     vld_ff [STAGES];
   item_type it_ff  [STAGES];

   val_type a1_ff, da1_ff, a2_ff, d2v_ff, err_ff, dv_ff;
   logic [REM_W-1:0] rem_ff  [QB+1];
   logic [VAL_W-1:0] dabs_ff [QB+1];
   logic [QB-1:0]    q_ff    [QB+1];
   logic             neg_ff  [QB+1];
   logic             zero_ff [QB+1];
   logic             sat_ff  [QB+1];
   item_type         res_in;

   poly_type px1, px2;
   logic [VAL_W-1:0] eabs, dabs;

   assign px1 = curve_poly(in_item.sel, 1'b0);
   assign px2 = curve_poly(it_ff[0].sel, 1'b0);
   assign eabs = err_ff[VAL_W-1] ? VAL_W'(-err_ff) : VAL_W'(err_ff);
   assign dabs = dv_ff[VAL_W-1] ? VAL_W'(-dv_ff) : VAL_W'(dv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it_ff[0] <= in_item;
         for (int i = 1; i < STAGES - 1; i++) it_ff[i] <= it_ff[i-1];
         it_ff[STAGES-1] <= res_in;
         a1_ff  <= val_type'(fx_mul(px1.c3, in_item.t) + px1.c2);
         da1_ff <= val_type'(fx_mul(px1.d3, in_item.t) + px1.d2);
         a2_ff  <= val_type'(fx_mul(a1_ff, it_ff[0].t) + px2.c1);
         d2v_ff <= val_type'(fx_mul(da1_ff, it_ff[0].t) + px2.c1);
         err_ff <= val_type'(fx_mul(a2_ff, it_ff[1].t) - val_type'({1'b0, it_ff[1].x}));
         dv_ff  <= d2v_ff;
         rem_ff[0]  <= {eabs, FRAC_BITS'(0)};
         dabs_ff[0] <= dabs;
         q_ff[0]    <= '0;
         neg_ff[0]  <= err_ff[VAL_W-1] ^ dv_ff[VAL_W-1];
         zero_ff[0] <= (dv_ff == '0);
         sat_ff[0]  <= ({2'b00, eabs} >= {dabs, 2'b00});
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_div
      logic [CMP_W-1:0] sh;
      logic             ge;
      assign sh = CMP_W'(dabs_ff[k-1]) << (QB - k);
      assign ge = CMP_W'(rem_ff[k-1]) >= sh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? REM_W'(rem_ff[k-1] - sh[REM_W-1:0]) : rem_ff[k-1];
            q_ff[k]    <= q_ff[k-1] | (ge ? (QB'(1) << (QB - k)) : QB'(0));
            dabs_ff[k] <= dabs_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
         end
      end
   end

   logic [QB:0]            qmag;
   logic signed [TS_W-1:0] qs, tn;

   always_comb begin
      res_in = it_ff[STAGES-2];
      if (zero_ff[QB])     qmag = '0;
      else if (sat_ff[QB]) qmag = (QB+1)'(1) << QB;
      else                 qmag = {1'b0, q_ff[QB]};
      qs = neg_ff[QB] ? -TS_W'($signed({1'b0, qmag})) : TS_W'($signed({1'b0, qmag}));
      tn = TS_W'($signed({1'b0, it_ff[STAGES-2].t})) - qs;
      if (tn < 0)                                 res_in.t = '0;
      else if (tn > TS_W'($signed({1'b0, ONE_X}))) res_in.t = ONE_X;
      else                                        res_in.t = tq_type'(tn);
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_item  = it_ff[STAGES-1];

endmodule

/* sv/cbe_y_eval.sv */
// Evaluates By(t) in Horner stages, saturates it and selects the end-point bypass.
// Depends on cbe_pkg.
`timescale 1ns / 1ps
module cbe_y_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cbe_pkg::item_type in_item,
   output logic              out_valid,
   output cbe_pkg::y_type    out_y
);
   import cbe_pkg::*;

   logic     vld_ff [4];
   item_type it_ff  [3];
   val_type  a1_ff, a2_ff, y3_ff;
   y_type    y_ff;
   poly_type py1, py2;
   val_type  ysat;

   assign py1 = curve_poly(in_item.sel, 1'b1);
   assign py2 = curve_poly(it_ff[0].sel, 1'b1);

   always_comb begin
      if (y3_ff < -ONE_V)           ysat = -ONE_V;
      else if (y3_ff > 2 * ONE_V)   ysat = val_type'(2 * ONE_V);
      else                          ysat = y3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it_ff[0] <= in_item;
         it_ff[1] <= it_ff[0];
         it_ff[2] <= it_ff[1];
         a1_ff <= val_type'(fx_mul(py1.c3, in_item.t) + py1.c2);
         a2_ff <= val_type'(fx_mul(a1_ff, it_ff[0].t) + py2.c1);
         y3_ff <= fx_mul(a2_ff, it_ff[1].t);
         y_ff  <= it_ff[2].pass ? y_type'({1'b0, it_ff[2].x}) : y_type'(ysat);
      end
   end

   assign out_valid = vld_ff[3];
   assign out_y     = y_ff;

endmodule

/* sv/cbe_skid_out.sv */
// Output register with one skid word; its fill state stalls the pipeline.
// Depends on cbe_pkg.
`timescale 1ns / 1ps
module cbe_skid_out (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  cbe_pkg::y_type in_y,
   output logic           en,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output cbe_pkg::y_type rsp_eased_y
);
   import cbe_pkg::*;

   logic  out_vld_ff, skid_vld_ff;
   y_type out_y_ff, skid_y_ff;
   logic  take, pop;

   assign en   = !skid_vld_ff;
   assign take = en && in_valid;
   assign pop  = out_vld_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || pop) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= take;
         end
      end else if (take) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || pop) begin
         out_y_ff <= skid_vld_ff ? skid_y_ff : in_y;
      end else if (take) begin
         skid_y_ff <= in_y;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_eased_y = out_y_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid word without output word");
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_ready))
      else $error("skid filled while output free");
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      pop && skid_vld_ff |=> out_vld_ff && !skid_vld_ff)
      else $error("skid word not moved to output");

endmodule
